FILE: design/mips_subset_execute_assert.svh
// Assertion macros shared by the execute block RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef MIPS_SUBSET_EXECUTE_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_ASSERT_SVH

`ifndef SYNTH
// Concurrent check on an explicit clock and active-low reset
`define MSE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Concurrent check on the block clock and reset
`define MSE_ASSERT(lbl, prop, msg) `MSE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define MSE_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define MSE_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: design/mse_pkg.sv
// Shared types and encodings for the MIPS subset execute block.
// No dependencies; used by mse_exec and mips_subset_execute.
package mse_pkg;

  // Reset value of the text base and of the program counter
  localparam logic [31:0] TEXT_BASE_RESET = 32'h0040_0000;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTR_COUNT = 2'd1;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_SW      = 6'd43;

  // Function codes of SPECIAL
  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLTU = 6'd43;

  // Link register of jal
  localparam logic [4:0] REG_RA = 5'd31;

  // Outcome of one executed instruction, carried down the pipeline
  typedef struct packed {
    logic [31:0] npc;
    logic        bad;
    logic        wr;     // register write, never to register zero
    logic [4:0]  dest;
    logic [31:0] val;
    logic        lw;     // write value comes from data memory
    logic        st;
    logic [31:0] maddr;
    logic [31:0] mval;
  } ex_res_t;

endpackage

FILE: design/mse_exec.sv
// Decode and ALU of the execute block: one instruction, operands already resolved.
// Depends on mse_pkg for opcodes and the result struct.
module mse_exec (
  input  logic [31:0]     instr_i,
  input  logic [31:0]     pc_i,
  input  logic            halted_i,
  input  logic [31:0]     rs_val_i,
  input  logic [31:0]     rt_val_i,
  output mse_pkg::ex_res_t res_o
);
  import mse_pkg::*;

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] sext;
  logic [31:0] zext;
  logic [31:0] pc4;
  logic [31:0] br_tgt;

  assign op     = instr_i[31:26];
  assign fn     = instr_i[5:0];
  assign rt     = instr_i[20:16];
  assign rd     = instr_i[15:11];
  assign sh     = instr_i[10:6];
  assign sext   = {{16{instr_i[15]}}, instr_i[15:0]};
  assign zext   = {16'h0000, instr_i[15:0]};
  assign pc4    = pc_i + 32'd4;
  assign br_tgt = pc4 + {sext[29:0], 2'b00};

  always_comb begin
    res_o = '0;
    res_o.npc = pc4;
    case (op)
      // register-register group
      OP_SPECIAL: begin
        res_o.wr = 1'b1;
        res_o.dest = rd;
        case (fn)
          FN_ADDU: res_o.val = rs_val_i + rt_val_i;
          FN_AND:  res_o.val = rs_val_i & rt_val_i;
          FN_JR: begin
            res_o.wr = 1'b0;
            res_o.npc = rs_val_i;
          end
          FN_NOR:  res_o.val = ~(rs_val_i | rt_val_i);
          FN_OR:   res_o.val = rs_val_i | rt_val_i;
          FN_SLTU: res_o.val = {31'd0, rs_val_i < rt_val_i};
          FN_SLL:  res_o.val = rt_val_i << sh;
          FN_SRL:  res_o.val = rt_val_i >> sh;
          FN_SUBU: res_o.val = rs_val_i - rt_val_i;
          default: begin
            res_o.wr = 1'b0;
            res_o.bad = 1'b1;
          end
        endcase
      end
      // jumps keep the upper nibble of pc+4
      OP_J: res_o.npc = {pc4[31:28], instr_i[25:0], 2'b00};
      OP_JAL: begin
        res_o.npc = {pc4[31:28], instr_i[25:0], 2'b00};
        res_o.wr = 1'b1;
        res_o.dest = REG_RA;
        res_o.val = pc4;
      end
      OP_ADDIU: begin
        res_o.wr = 1'b1;
        res_o.dest = rt;
        res_o.val = rs_val_i + sext;
      end
      OP_ANDI: begin
        res_o.wr = 1'b1;
        res_o.dest = rt;
        res_o.val = rs_val_i & zext;
      end
      OP_ORI: begin
        res_o.wr = 1'b1;
        res_o.dest = rt;
        res_o.val = rs_val_i | zext;
      end
      OP_LUI: begin
        res_o.wr = 1'b1;
        res_o.dest = rt;
        res_o.val = {instr_i[15:0], 16'h0000};
      end
      OP_SLTIU: begin
        res_o.wr = 1'b1;
        res_o.dest = rt;
        res_o.val = {31'd0, rs_val_i < sext};
      end
      OP_BEQ: if (rs_val_i == rt_val_i) res_o.npc = br_tgt;
      OP_BNE: if (rs_val_i != rt_val_i) res_o.npc = br_tgt;
      OP_LW: begin
        res_o.wr = 1'b1;
        res_o.dest = rt;
        res_o.lw = 1'b1;
        res_o.maddr = rs_val_i + sext;
      end
      OP_SW: begin
        res_o.st = 1'b1;
        res_o.maddr = rs_val_i + sext;
        res_o.mval = rt_val_i;
      end
      default: res_o.bad = 1'b1;
    endcase

    // illegal word or halted core: PC holds, nothing written
    if (res_o.bad || halted_i) begin
      res_o = '0;
      res_o.npc = pc_i;
      res_o.bad = 1'b1;
    end

    // register zero is never written
    if (res_o.dest == '0) begin
      res_o.wr = 1'b0;
    end
    if (!res_o.wr) begin
      res_o.dest = '0;
      res_o.val = '0;
      res_o.lw = 1'b0;
    end
  end

endmodule

FILE: design/mips_subset_execute.sv
// Top level of the MIPS subset execute block: pipeline, register file, data memory.
// Depends on mse_pkg, mse_exec and mips_subset_execute_assert.svh.
//
// Usage: each transfer on the input channel carries the instruction word found at
// the PC last reported (the reset PC is the text base reset value). Each input
// transfer yields exactly one result transfer on the output channel: next PC,
// running flag, illegal-instruction flag, register write and store details.
// Configuration writes (text base, instruction count) go over the cfg channel,
// which is always ready; write them only while no instruction is in flight.
// Pipeline: execute, address fold, memory, output register. One instruction is
// taken per cycle unless a stall holds the input; a load followed by one of the
// next two instructions that reads the loaded register holds the input while the
// load is in address fold or memory (load-to-use forwarding is only available
// from the output register, where the memory read data lands).
// The address fold needs one 30x32 multiply for the word index modulo
// DATA_WORDS. Reset clears PC, halt flag, configuration and register file
// (through per-register valid bits); data memory is not cleared. When the
// receiver stalls, the pipeline fills and then stalls the input.
`include "mips_subset_execute_assert.svh"

module mips_subset_execute #(
  parameter int unsigned DATA_WORDS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [31:0]                    instr_word_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    next_pc_o,
  output logic                           running_o,
  output logic                           bad_instruction_o,
  output logic                           reg_written_o,
  output logic [4:0]                     reg_index_o,
  output logic [31:0]                    reg_value_o,
  output logic                           mem_stored_o,
  output logic [31:0]                    mem_address_o,
  output logic [31:0]                    mem_value_o,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import mse_pkg::*;

  // word index = (addr >> 2) mod DATA_WORDS via exact reciprocal multiply
  localparam int unsigned IdxW       = $clog2(DATA_WORDS);
  localparam int unsigned RecipShift = 30 + IdxW;
  localparam int unsigned QuotW      = 31 - IdxW;
  localparam longint unsigned RecipFull =
    ((64'd1 << RecipShift) + 64'(DATA_WORDS) - 64'd1) / 64'(DATA_WORDS);
  localparam logic [31:0]     Recip     = 32'(RecipFull);
  localparam logic [IdxW-1:0] DwLow     = IdxW'(DATA_WORDS);

  // configuration
  logic [31:0] text_base_q;
  logic [16:0] instr_count_q;

  // architectural state
  logic [31:0] pc_q;
  logic        halted_q;
  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid_q;
  logic [31:0] dmem [DATA_WORDS];

  // stage valids and payloads
  logic             ex_valid_q, ag_valid_q, mx_valid_q, out_valid_q;
  logic [31:0]      ex_instr_q;
  logic [31:0]      ex_rs_q, ex_rt_q;
  ex_res_t          ex_res, ag_res_q, mx_res_q, out_res_q;
  logic             mx_run_q, out_run_q;
  logic [QuotW-1:0] mx_quot_q;
  logic [31:0]      mem_rdata_q;

  // handshake and flow control
  logic in_acc, ex_adv, ag_adv, mx_adv, out_adv, ld_hazard;

  // register file write port (at output transfer)
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic [4:0]  rd_rs, rd_rt;

  // execute operands after forwarding
  logic [4:0]  ex_rs_idx, ex_rt_idx;
  logic [31:0] op_a, op_b;

  // address fold and running check
  logic [29:0]      ag_word;
  logic [61:0]      ag_prod;
  logic [QuotW-1:0] ag_quot;
  logic [31:0]      ag_diff;
  logic             ag_run;
  logic [IdxW-1:0]  mem_idx;

  // ---------------------------------------------------------------------------
  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_base_q   <= TEXT_BASE_RESET;
      instr_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TEXT_BASE:   text_base_q   <= cfg_data_i;
        CFG_INSTR_COUNT: instr_count_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: each stage moves when the next one is empty or moving
  assign ex_rs_idx = ex_instr_q[25:21];
  assign ex_rt_idx = ex_instr_q[20:16];

  // a load still in flight cannot feed the execute stage yet
  assign ld_hazard =
    (ag_valid_q && ag_res_q.lw && (ag_res_q.dest == ex_rs_idx || ag_res_q.dest == ex_rt_idx)) ||
    (mx_valid_q && mx_res_q.lw && (mx_res_q.dest == ex_rs_idx || mx_res_q.dest == ex_rt_idx));

  assign out_adv    = out_valid_q && !out_stall_i;
  assign mx_adv     = mx_valid_q && (!out_valid_q || out_adv);
  assign ag_adv     = ag_valid_q && (!mx_valid_q || mx_adv);
  assign ex_adv     = ex_valid_q && !ld_hazard && (!ag_valid_q || ag_adv);
  assign in_stall_o = ex_valid_q && !ex_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      ag_valid_q  <= 1'b0;
      mx_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) ex_valid_q <= 1'b1;
      else if (ex_adv) ex_valid_q <= 1'b0;
      if (ex_adv) ag_valid_q <= 1'b1;
      else if (ag_adv) ag_valid_q <= 1'b0;
      if (ag_adv) mx_valid_q <= 1'b1;
      else if (mx_adv) mx_valid_q <= 1'b0;
      if (mx_adv) out_valid_q <= 1'b1;
      else if (out_adv) out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // register file: two registered read ports with write bypass, valid bits
  assign rf_we = out_adv && out_res_q.wr;
  assign rf_wa = out_res_q.dest;
  assign rf_wd = out_res_q.lw ? mem_rdata_q : out_res_q.val;

  // re-read every cycle an item waits in execute, so its operands stay current
  assign rd_rs = in_stall_o ? ex_rs_idx : instr_word_i[25:21];
  assign rd_rt = in_stall_o ? ex_rt_idx : instr_word_i[20:16];

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (rf_we && rf_wa == rd_rs) ex_rs_q <= rf_wd;
    else if (!rf_valid_q[rd_rs]) ex_rs_q <= '0;
    else ex_rs_q <= rf_mem[rd_rs];
    if (rf_we && rf_wa == rd_rt) ex_rt_q <= rf_wd;
    else if (!rf_valid_q[rd_rt]) ex_rt_q <= '0;
    else ex_rt_q <= rf_mem[rd_rt];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
    end else if (rf_we) begin
      rf_valid_q[rf_wa] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // execute stage
  always_ff @(posedge clk_i) begin
    if (in_acc) ex_instr_q <= instr_word_i;
  end

  // forwarding, youngest writer first
  function automatic logic [31:0] fwd_sel(input logic [4:0] idx, input logic [31:0] rdata);
    logic [31:0] v;
    if (ag_valid_q && ag_res_q.wr && ag_res_q.dest == idx) v = ag_res_q.val;
    else if (mx_valid_q && mx_res_q.wr && mx_res_q.dest == idx) v = mx_res_q.val;
    else if (out_valid_q && out_res_q.wr && out_res_q.dest == idx) v = rf_wd;
    else v = rdata;
    return v;
  endfunction

  always_comb op_a = fwd_sel(ex_rs_idx, ex_rs_q);
  always_comb op_b = fwd_sel(ex_rt_idx, ex_rt_q);

  mse_exec u_exec (
    .instr_i  (ex_instr_q),
    .pc_i     (pc_q),
    .halted_i (halted_q),
    .rs_val_i (op_a),
    .rt_val_i (op_b),
    .res_o    (ex_res)
  );

  // PC and halt flag follow the instruction leaving execute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= TEXT_BASE_RESET;
      halted_q <= 1'b0;
    end else if (ex_adv) begin
      pc_q <= ex_res.npc;
      if (ex_res.bad) halted_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_adv) ag_res_q <= ex_res;
  end

  // ---------------------------------------------------------------------------
  // address fold stage: quotient of word address, running check
  assign ag_word = ag_res_q.maddr[31:2];
  assign ag_prod = 62'(ag_word) * 62'(Recip);
  assign ag_quot = ag_prod[RecipShift +: QuotW];
  assign ag_diff = ag_res_q.npc - text_base_q;
  assign ag_run  = !ag_res_q.bad && (ag_diff[31:2] < 30'(instr_count_q));

  always_ff @(posedge clk_i) begin
    if (ag_adv) begin
      mx_res_q  <= ag_res_q;
      mx_quot_q <= ag_quot;
      mx_run_q  <= ag_run;
    end
  end

  // ---------------------------------------------------------------------------
  // memory stage: remainder gives the entry, store and registered load
  assign mem_idx = mx_res_q.maddr[IdxW+1:2] - (IdxW'(mx_quot_q) * DwLow);

  always_ff @(posedge clk_i) begin
    if (mx_adv && mx_res_q.st) dmem[mem_idx] <= mx_res_q.mval;
    if (mx_adv) mem_rdata_q <= dmem[mem_idx];
  end

  always_ff @(posedge clk_i) begin
    if (mx_adv) begin
      out_res_q <= mx_res_q;
      out_run_q <= mx_run_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  assign out_valid_o       = out_valid_q;
  assign next_pc_o         = out_res_q.npc;
  assign running_o         = out_run_q;
  assign bad_instruction_o = out_res_q.bad;
  assign reg_written_o     = out_res_q.wr;
  assign reg_index_o       = out_res_q.dest;
  assign reg_value_o       = rf_wd;
  assign mem_stored_o      = out_res_q.st;
  assign mem_address_o     = out_res_q.maddr;
  assign mem_value_o       = out_res_q.mval;

  // ---------------------------------------------------------------------------
  // checks
  `MSE_ASSERT(a_halt_sticky, halted_q |=> halted_q, "halt flag cleared without reset")
  `MSE_ASSERT(a_bad_holds_pc, (ex_adv && ex_res.bad) |=> (pc_q == $past(pc_q)), "PC moved on illegal word")
  `MSE_ASSERT(a_no_r0_write, rf_we |-> (rf_wa != '0), "write to register zero")
  `MSE_ASSERT(a_bad_is_quiet, (out_valid_q && out_res_q.bad) |-> (!out_res_q.wr && !out_res_q.st), "illegal word has side effects")
  `MSE_ASSERT(a_idx_range, mx_adv |-> (32'(mem_idx) < 32'(DATA_WORDS)), "data memory index out of range")

endmodule
